>>> src/dlhm_pkg.sv
// ----------------------------------------------------------------------------
// Line hull package
// Sizes, codes and the stored line word of the upper-envelope line table.
// ----------------------------------------------------------------------------
package dlhm_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int SLOPE_W  = 32;
  localparam int ICPT_W   = 63;
  localparam int VALUE_W  = 64;
  localparam int STAT_W   = 2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

  localparam logic [VALUE_W-1:0] BIG_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [VALUE_W-1:0] BIG_NEG = 64'h8000_0000_0000_0001;

  typedef struct packed {
    logic signed [SLOPE_W-1:0] slope;
    logic signed [ICPT_W-1:0]  intercept;
  } line_t;

  function automatic logic signed [VALUE_W-1:0] ext_icpt(input logic [ICPT_W-1:0] b);
    ext_icpt = {b[ICPT_W-1], b};
  endfunction

endpackage

>>> src/dynamic_line_hull_max.sv
// ----------------------------------------------------------------------------
// Dynamic line hull, maximum form
// Keeps the upper envelope of lines in a slope-sorted table held in one
// synchronous memory, with insert and point-maximum query commands.
// ----------------------------------------------------------------------------
//  channel | ports                                        | handshake
//  input   | in_cmd, in_slope, in_intercept, in_query_x   | start high, busy low
//  result  | out_value, out_status                        | out_valid, one cycle
//
// A query runs a binary search over the stored lines.
// An insert runs a binary search, moves each later line up one slot to open a slot,
// checks neighbors with up to two 64-step serial divisions each, and moves each
// later line down one slot on each removal.
// Reset empties the table at once; the memory itself is never cleared.
// The result is shown for one cycle and cannot be stalled.
module dynamic_line_hull_max (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_cmd,
  input  logic signed [dlhm_pkg::SLOPE_W-1:0] in_slope,
  input  logic signed [dlhm_pkg::ICPT_W-1:0]  in_intercept,
  input  logic signed [dlhm_pkg::SLOPE_W-1:0] in_query_x,
  output logic                           out_valid,
  output logic signed [dlhm_pkg::VALUE_W-1:0] out_value,
  output logic [dlhm_pkg::STAT_W-1:0]    out_status
);
  import dlhm_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_F_ADDR, S_F_CMP, S_SH_RD, S_SH_WR, S_NEXT,
    S_C_R0, S_C_R1, S_C_R2, S_C_R3, S_C_V1, S_C_V2, S_D_RUN, S_D_FIN,
    S_C_CMP, S_DECIDE, S_RM_RD, S_RM_WR,
    S_Q_ADDR, S_Q_A, S_Q_B, S_Q_MUL, S_Q_CMP, S_Q_F1, S_Q_F2
  } state_t;

  typedef enum logic [1:0] {PH_NEW, PH_RIGHT, PH_LEFT} phase_t;

  state_t state_r;
  phase_t phase_r;

  line_t mem [CAPACITY];
  line_t q_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  line_t             mem_wdata;

  logic [CNT_W-1:0] count_r, lo_r, hi_r, mid_r, pos_r, k_r, i_r;
  logic [CNT_W:0]   mid_sum;
  logic [CNT_W-1:0] mid_w, km1, kp1, im1, ip1, midp1;
  logic             has_l, has_r;

  logic signed [SLOPE_W-1:0] m_in_r, x_r;
  logic signed [ICPT_W-1:0]  b_in_r;
  line_t a_r, b_r, c_r;
  logic                      ul_r;
  logic [VALUE_W-1:0]        v1_r, v2_r;

  logic [SLOPE_W-1:0] dvs_r;
  logic [SLOPE_W-1:0] rem_r;
  logic [VALUE_W-1:0] quo_r;
  logic               neg_r, sel_r;
  logic [5:0]         dcnt_r;
  logic [SLOPE_W:0]   d_trial, d_sub;

  logic signed [VALUE_W:0]   prod_r;
  logic signed [SLOPE_W:0]   dm_q;
  logic signed [VALUE_W-1:0] lhs_q;

  logic signed [VALUE_W-1:0] dvd1, dvd2;
  logic signed [SLOPE_W:0]   dsr1, dsr2;

  logic                       out_valid_r;
  logic signed [VALUE_W-1:0]  out_value_r;
  logic [STAT_W-1:0]          out_status_r;

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_w   = mid_sum[CNT_W:1];
  assign km1     = k_r - 1'b1;
  assign kp1     = k_r + 1'b1;
  assign im1     = i_r - 1'b1;
  assign ip1     = i_r + 1'b1;
  assign midp1   = mid_r + 1'b1;
  assign has_l   = (i_r != '0);
  assign has_r   = (ip1 < count_r);

  assign dvd1 = ext_icpt(a_r.intercept) - ext_icpt(b_r.intercept);
  assign dvd2 = ext_icpt(b_r.intercept) - ext_icpt(c_r.intercept);
  assign dsr1 = {b_r.slope[SLOPE_W-1], b_r.slope} - {a_r.slope[SLOPE_W-1], a_r.slope};
  assign dsr2 = {c_r.slope[SLOPE_W-1], c_r.slope} - {b_r.slope[SLOPE_W-1], b_r.slope};

  assign d_trial = {rem_r, quo_r[VALUE_W-1]};
  assign d_sub   = d_trial - {1'b0, dvs_r};

  assign dm_q  = {c_r.slope[SLOPE_W-1], c_r.slope} - {a_r.slope[SLOPE_W-1], a_r.slope};
  assign lhs_q = ext_icpt(a_r.intercept) - ext_icpt(c_r.intercept);

  always_comb begin
    mem_raddr = '0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = q_r;
    case (state_r)
      S_F_ADDR: mem_raddr = mid_w[ADDR_W-1:0];
      S_SH_RD: begin
        mem_raddr = km1[ADDR_W-1:0];
        if (k_r == pos_r) begin
          mem_we    = 1'b1;
          mem_waddr = pos_r[ADDR_W-1:0];
          mem_wdata = '{slope: m_in_r, intercept: b_in_r};
        end
      end
      S_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = k_r[ADDR_W-1:0];
      end
      S_C_R0: mem_raddr = im1[ADDR_W-1:0];
      S_C_R1: mem_raddr = i_r[ADDR_W-1:0];
      S_C_R2: mem_raddr = ip1[ADDR_W-1:0];
      S_RM_RD: mem_raddr = kp1[ADDR_W-1:0];
      S_RM_WR: begin
        mem_we    = 1'b1;
        mem_waddr = k_r[ADDR_W-1:0];
      end
      S_Q_ADDR: mem_raddr = (lo_r < hi_r) ? mid_w[ADDR_W-1:0] : lo_r[ADDR_W-1:0];
      S_Q_A: mem_raddr = midp1[ADDR_W-1:0];
      default: mem_raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    q_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_NEW;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            m_in_r <= in_slope;
            b_in_r <= in_intercept;
            x_r    <= in_query_x;
            if (in_cmd == CMD_INSERT) begin
              if (count_r == CNT_W'(CAPACITY)) begin
                out_valid_r  <= 1'b1;
                out_value_r  <= '0;
                out_status_r <= STATUS_FULL;
              end else begin
                lo_r    <= '0;
                hi_r    <= count_r;
                state_r <= S_F_ADDR;
              end
            end else begin
              if (count_r == '0) begin
                out_valid_r  <= 1'b1;
                out_value_r  <= '0;
                out_status_r <= STATUS_EMPTY;
              end else begin
                lo_r    <= '0;
                hi_r    <= count_r - 1'b1;
                state_r <= S_Q_ADDR;
              end
            end
          end
        end
        S_F_ADDR: begin
          if (lo_r < hi_r) begin
            mid_r   <= mid_w;
            state_r <= S_F_CMP;
          end else begin
            pos_r   <= lo_r;
            k_r     <= count_r;
            state_r <= S_SH_RD;
          end
        end
        S_F_CMP: begin
          if (q_r.slope <= m_in_r) begin
            lo_r <= midp1;
          end else begin
            hi_r <= mid_r;
          end
          state_r <= S_F_ADDR;
        end
        S_SH_RD: begin
          if (k_r > pos_r) begin
            state_r <= S_SH_WR;
          end else begin
            count_r <= count_r + 1'b1;
            phase_r <= PH_NEW;
            state_r <= S_NEXT;
          end
        end
        S_SH_WR: begin
          k_r     <= km1;
          state_r <= S_SH_RD;
        end
        S_NEXT: begin
          unique case (phase_r)
            PH_NEW: begin
              i_r     <= pos_r;
              state_r <= S_C_R0;
            end
            PH_RIGHT: begin
              if (pos_r + 1'b1 < count_r) begin
                i_r     <= pos_r + 1'b1;
                state_r <= S_C_R0;
              end else begin
                phase_r <= PH_LEFT;
              end
            end
            PH_LEFT: begin
              if (pos_r != '0) begin
                i_r     <= pos_r - 1'b1;
                state_r <= S_C_R0;
              end else begin
                out_valid_r  <= 1'b1;
                out_value_r  <= '0;
                out_status_r <= STATUS_OK;
                state_r      <= S_IDLE;
              end
            end
            default: state_r <= S_IDLE;
          endcase
        end
        S_C_R0: state_r <= S_C_R1;
        S_C_R1: begin
          a_r     <= q_r;
          state_r <= S_C_R2;
        end
        S_C_R2: begin
          b_r     <= q_r;
          state_r <= S_C_R3;
        end
        S_C_R3: begin
          c_r     <= q_r;
          state_r <= S_C_V1;
        end
        S_C_V1: begin
          if (!(has_l && has_r)) begin
            if (has_l) begin
              ul_r <= (b_r.slope == a_r.slope) && (b_r.intercept <= a_r.intercept);
            end else begin
              ul_r <= has_r && (b_r.slope == c_r.slope) && (b_r.intercept <= c_r.intercept);
            end
            state_r <= S_DECIDE;
          end else if (b_r.slope == a_r.slope) begin
            v1_r    <= (a_r.intercept > b_r.intercept) ? BIG_POS : BIG_NEG;
            state_r <= S_C_V2;
          end else begin
            neg_r   <= dvd1[VALUE_W-1];
            quo_r   <= dvd1[VALUE_W-1] ? VALUE_W'(-dvd1) : VALUE_W'(dvd1);
            rem_r   <= '0;
            dvs_r   <= dsr1[SLOPE_W-1:0];
            dcnt_r  <= '1;
            sel_r   <= 1'b0;
            state_r <= S_D_RUN;
          end
        end
        S_C_V2: begin
          if (c_r.slope == b_r.slope) begin
            v2_r    <= (b_r.intercept > c_r.intercept) ? BIG_POS : BIG_NEG;
            state_r <= S_C_CMP;
          end else begin
            neg_r   <= dvd2[VALUE_W-1];
            quo_r   <= dvd2[VALUE_W-1] ? VALUE_W'(-dvd2) : VALUE_W'(dvd2);
            rem_r   <= '0;
            dvs_r   <= dsr2[SLOPE_W-1:0];
            dcnt_r  <= '1;
            sel_r   <= 1'b1;
            state_r <= S_D_RUN;
          end
        end
        S_D_RUN: begin
          if (!d_sub[SLOPE_W]) begin
            rem_r <= d_sub[SLOPE_W-1:0];
            quo_r <= {quo_r[VALUE_W-2:0], 1'b1};
          end else begin
            rem_r <= d_trial[SLOPE_W-1:0];
            quo_r <= {quo_r[VALUE_W-2:0], 1'b0};
          end
          dcnt_r <= dcnt_r - 1'b1;
          if (dcnt_r == '0) begin
            state_r <= S_D_FIN;
          end
        end
        S_D_FIN: begin
          if (!sel_r) begin
            v1_r    <= neg_r ? (~quo_r + 1'b1) : quo_r;
            state_r <= S_C_V2;
          end else begin
            v2_r    <= neg_r ? (~quo_r + 1'b1) : quo_r;
            state_r <= S_C_CMP;
          end
        end
        S_C_CMP: begin
          ul_r    <= $signed(v1_r) >= $signed(v2_r);
          state_r <= S_DECIDE;
        end
        S_DECIDE: begin
          if (ul_r) begin
            k_r     <= i_r;
            state_r <= S_RM_RD;
          end else begin
            unique case (phase_r)
              PH_NEW: begin
                phase_r <= PH_RIGHT;
                state_r <= S_NEXT;
              end
              PH_RIGHT: begin
                phase_r <= PH_LEFT;
                state_r <= S_NEXT;
              end
              default: begin
                out_valid_r  <= 1'b1;
                out_value_r  <= '0;
                out_status_r <= STATUS_OK;
                state_r      <= S_IDLE;
              end
            endcase
          end
        end
        S_RM_RD: begin
          if (kp1 < count_r) begin
            state_r <= S_RM_WR;
          end else begin
            count_r <= count_r - 1'b1;
            unique case (phase_r)
              PH_NEW: begin
                out_valid_r  <= 1'b1;
                out_value_r  <= '0;
                out_status_r <= STATUS_OK;
                state_r      <= S_IDLE;
              end
              PH_RIGHT: state_r <= S_NEXT;
              default: begin
                pos_r   <= pos_r - 1'b1;
                state_r <= S_NEXT;
              end
            endcase
          end
        end
        S_RM_WR: begin
          k_r     <= kp1;
          state_r <= S_RM_RD;
        end
        S_Q_ADDR: begin
          if (lo_r < hi_r) begin
            mid_r   <= mid_w;
            state_r <= S_Q_A;
          end else begin
            state_r <= S_Q_F1;
          end
        end
        S_Q_A: begin
          a_r     <= q_r;
          state_r <= S_Q_B;
        end
        S_Q_B: begin
          c_r     <= q_r;
          state_r <= S_Q_MUL;
        end
        S_Q_MUL: begin
          prod_r  <= dm_q * x_r;
          state_r <= S_Q_CMP;
        end
        S_Q_CMP: begin
          if ($signed({lhs_q[VALUE_W-1], lhs_q}) < prod_r) begin
            lo_r <= midp1;
          end else begin
            hi_r <= mid_r;
          end
          state_r <= S_Q_ADDR;
        end
        S_Q_F1: begin
          b_r     <= q_r;
          prod_r  <= q_r.slope * x_r;
          state_r <= S_Q_F2;
        end
        S_Q_F2: begin
          out_valid_r  <= 1'b1;
          out_value_r  <= prod_r[VALUE_W-1:0] + ext_icpt(b_r.intercept);
          out_status_r <= STATUS_OK;
          state_r      <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("line count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == $past(count_r)) || (count_r == $past(count_r) + 1'b1) ||
    (count_r + 1'b1 == $past(count_r)))
    else $error("line count moved by more than one");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_D_RUN) |-> (dvs_r != '0))
    else $error("division by zero slope difference");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == STATUS_FULL) |-> (count_r == CNT_W'(CAPACITY)))
    else $error("full status while table has room");

endmodule
